@@ src/positional_array_list_macros.svh @@
// ----------------------------------------------------------------------------
// positional_array_list_macros.svh
// Assertion helpers used by the top level of the list RTL.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_LIST_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_MACROS_SVH

// same-cycle implication, disabled during reset
`define PLST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define PLST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/plst_pkg.sv @@
// ----------------------------------------------------------------------------
// plst_pkg
// Operation and status codes and the control structs of the list block.
// ----------------------------------------------------------------------------
`default_nettype none

package plst_pkg;

   localparam logic [1:0] OP_READ   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_FULL   = 2'd1;
   localparam logic [1:0] STAT_EMPTY  = 2'd2;
   localparam logic [1:0] STAT_BADPOS = 2'd3;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] status;
      logic       rd_ok;
   } done_type;

endpackage

`default_nettype wire

@@ src/plst_mem.sv @@
// ----------------------------------------------------------------------------
// plst_mem
// Entry store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module plst_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  wire logic                       clock,
   input  wire plst_pkg::mem_ctl_type      mem_ctl,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);
   import plst_pkg::*;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/plst_ctrl.sv @@
// ----------------------------------------------------------------------------
// plst_ctrl
// Operation sequencer: checks, then reads an entry or moves entries through
// the store one per cycle (read a slot, write it to its neighbor next cycle).
// ----------------------------------------------------------------------------
`default_nettype none

module plst_ctrl #(
   parameter int CAPACITY   = 64,
   parameter int ENTRY_BITS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_op,
   input  wire logic [6:0]                    req_position,
   input  wire logic [31:0]                   req_entry_in,
   output plst_pkg::mem_ctl_type              mem_ctl,
   output logic      [$clog2(CAPACITY)-1:0]   wr_addr,
   output logic      [ENTRY_BITS-1:0]         wr_data,
   output logic      [$clog2(CAPACITY)-1:0]   rd_addr,
   input  wire logic [ENTRY_BITS-1:0]         rd_data,
   output plst_pkg::done_type                 done,
   output logic      [$clog2(CAPACITY+1)-1:0] count_next
);
   import plst_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = ((CW > 7) ? CW : 7) + 1;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_RDWAIT = 3'd2;
   localparam logic [2:0] S_SHUP   = 3'd3;
   localparam logic [2:0] S_WRNEW  = 3'd4;
   localparam logic [2:0] S_SHDN   = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [1:0]            op_ff, op_in;
   logic [6:0]            pos_ff, pos_in;
   logic [ENTRY_BITS-1:0] val_ff, val_in;
   logic [AW-1:0]         dst_ff, dst_in;

   logic [PW-1:0] pos_x, cnt_x, pos_m1;
   logic          lst_empty, lst_full, rd_bad, ins_bad;

   assign pos_x     = PW'(pos_ff);
   assign cnt_x     = PW'(count_ff);
   assign pos_m1    = pos_x - PW'(1);
   assign lst_empty = (count_ff == '0);
   assign lst_full  = (cnt_x == PW'(CAPACITY));
   assign rd_bad    = (pos_x == '0) || (pos_x > cnt_x);
   assign ins_bad   = (pos_x == '0) || (pos_x > cnt_x + PW'(1));

   assign busy       = (state_ff != S_IDLE);
   assign count_next = count_in;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      op_in    = op_ff;
      pos_in   = pos_ff;
      val_in   = val_ff;
      dst_in   = dst_ff;
      mem_ctl  = '0;
      wr_addr  = dst_ff;
      wr_data  = rd_data;
      rd_addr  = '0;
      done     = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_op;
               pos_in   = req_position;
               val_in   = ENTRY_BITS'(req_entry_in);
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            case (op_ff)
               OP_READ: begin
                  if (lst_empty) begin
                     done     = '{valid: 1'b1, status: STAT_EMPTY, rd_ok: 1'b0};
                     state_in = S_IDLE;
                  end else if (rd_bad) begin
                     done     = '{valid: 1'b1, status: STAT_BADPOS, rd_ok: 1'b0};
                     state_in = S_IDLE;
                  end else begin
                     mem_ctl.rd_en = 1'b1;
                     rd_addr       = pos_m1[AW-1:0];
                     state_in      = S_RDWAIT;
                  end
               end
               OP_INSERT: begin
                  if (lst_full) begin
                     done     = '{valid: 1'b1, status: STAT_FULL, rd_ok: 1'b0};
                     state_in = S_IDLE;
                  end else if (ins_bad) begin
                     done     = '{valid: 1'b1, status: STAT_BADPOS, rd_ok: 1'b0};
                     state_in = S_IDLE;
                  end else if (pos_x == cnt_x + PW'(1)) begin
                     // append: nothing to move
                     state_in = S_WRNEW;
                  end else begin
                     // top entry moves first
                     mem_ctl.rd_en = 1'b1;
                     rd_addr       = count_ff[AW-1:0] - AW'(1);
                     dst_in        = count_ff[AW-1:0];
                     state_in      = S_SHUP;
                  end
               end
               OP_DELETE: begin
                  if (lst_empty) begin
                     done     = '{valid: 1'b1, status: STAT_EMPTY, rd_ok: 1'b0};
                     state_in = S_IDLE;
                  end else if (rd_bad) begin
                     done     = '{valid: 1'b1, status: STAT_BADPOS, rd_ok: 1'b0};
                     state_in = S_IDLE;
                  end else if (pos_x == cnt_x) begin
                     // last entry: just drop it
                     count_in = count_ff - CW'(1);
                     done     = '{valid: 1'b1, status: STAT_OK, rd_ok: 1'b0};
                     state_in = S_IDLE;
                  end else begin
                     mem_ctl.rd_en = 1'b1;
                     rd_addr       = pos_x[AW-1:0];
                     dst_in        = pos_m1[AW-1:0];
                     state_in      = S_SHDN;
                  end
               end
               default: begin
                  done     = '{valid: 1'b1, status: STAT_BADPOS, rd_ok: 1'b0};
                  state_in = S_IDLE;
               end
            endcase
         end
         S_RDWAIT: begin
            done     = '{valid: 1'b1, status: STAT_OK, rd_ok: 1'b1};
            state_in = S_IDLE;
         end
         S_SHUP: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = dst_ff;
            wr_data       = rd_data;
            if (PW'(dst_ff) == pos_x) begin
               state_in = S_WRNEW;
            end else begin
               // read two below while writing: never the slot just written
               mem_ctl.rd_en = 1'b1;
               rd_addr       = (dst_ff - AW'(1)) - AW'(1);
               dst_in        = dst_ff - AW'(1);
            end
         end
         S_WRNEW: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = pos_m1[AW-1:0];
            wr_data       = val_ff;
            count_in      = count_ff + CW'(1);
            done          = '{valid: 1'b1, status: STAT_OK, rd_ok: 1'b0};
            state_in      = S_IDLE;
         end
         S_SHDN: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = dst_ff;
            wr_data       = rd_data;
            if (PW'(dst_ff) + PW'(2) == cnt_x) begin
               count_in = count_ff - CW'(1);
               done     = '{valid: 1'b1, status: STAT_OK, rd_ok: 1'b0};
               state_in = S_IDLE;
            end else begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = (dst_ff + AW'(1)) + AW'(1);
               dst_in        = dst_ff + AW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      pos_ff <= pos_in;
      val_ff <= val_in;
      dst_ff <= dst_in;
   end

endmodule

`default_nettype wire

@@ src/positional_array_list.sv @@
// ----------------------------------------------------------------------------
// positional_array_list
// Bounded list of entries addressed by 1-based position: read, insert, delete.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low; exactly one
// result follows, shown for one cycle with rsp_valid, and the receiver has
// no way to hold it off. busy drops in the cycle the result is shown, so the
// next operation may be started then. Entries sit in a single memory with
// one read and one write port; inserts and deletes move one entry per cycle
// through it. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_array_list #(
   parameter int CAPACITY   = 64,
   parameter int ENTRY_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_op,
   input  wire logic [6:0]  req_position,
   input  wire logic [31:0] req_entry_in,
   output logic             rsp_valid,
   output logic      [1:0]  rsp_status,
   output logic      [31:0] rsp_entry_out,
   output logic      [6:0]  rsp_length,
   output logic             rsp_is_empty,
   output logic             rsp_is_full
);
   import plst_pkg::*;

`include "positional_array_list_macros.svh"

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   mem_ctl_type           mem_ctl;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [ENTRY_BITS-1:0] wr_data, rd_data;
   done_type              done;
   logic [CW-1:0]         count_next;

   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic [31:0] rsp_entry_out_ff;
   logic [6:0]  rsp_length_ff;
   logic        rsp_is_empty_ff, rsp_is_full_ff;

   plst_ctrl #(
      .CAPACITY   (CAPACITY),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_op       (req_op),
      .req_position (req_position),
      .req_entry_in (req_entry_in),
      .mem_ctl      (mem_ctl),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .done         (done),
      .count_next   (count_next)
   );

   plst_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (ENTRY_BITS)
   ) u_mem (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= done.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (done.valid) begin
         rsp_status_ff    <= done.status;
         rsp_entry_out_ff <= done.rd_ok ? 32'(rd_data) : '0;
         rsp_length_ff    <= 7'(count_next);
         rsp_is_empty_ff  <= (count_next == '0);
         rsp_is_full_ff   <= (count_next == CW'(CAPACITY));
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_entry_out = rsp_entry_out_ff;
   assign rsp_length    = rsp_length_ff;
   assign rsp_is_empty  = rsp_is_empty_ff;
   assign rsp_is_full   = rsp_is_full_ff;

   `PLST_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "busy missing after start")
   `PLST_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_valid, !busy, "result while still busy")
   `PLST_ASSERT_NOW(a_rsp_after_work, clock, reset, rsp_valid, $past(busy), "result without work")
   `PLST_ASSERT_NOW(a_flags_excl, clock, reset, rsp_valid, !(rsp_is_empty && rsp_is_full), "empty and full")
   `PLST_ASSERT_NOW(a_mem_ports, clock, reset, mem_ctl.wr_en && mem_ctl.rd_en, wr_addr != rd_addr, "read and write same slot")

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for positional_array_list. A short table of directed
// operations covers the empty, full and bad-position rejections, the unused
// op code and shifts at the front, middle and end. A fill to capacity sits
// inside the table. Random list traffic then grows and shrinks the list
// across its whole range under three sender idle profiles. Every result is
// checked field by field against its row's expectation or a shadow copy of the list.
// ----------------------------------------------------------------------------

module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import plst_pkg::*;

   localparam int          CAPACITY     = 64;
   localparam logic [1:0]  OP_UNUSED    = 2'd3;
   localparam int          CYCLE_LIMIT  = 1_000_000;
   localparam int          TAIL_CYCLES  = 80;   // longer than the longest insert
   localparam int          PHASE_ITEMS  = 240;
   localparam int          N_DIRECTED   = 26;
   localparam int          FULL_ROWS_AT = 21;   // the list is filled before this row

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] entry_out;
      logic [6:0]  length;
      logic        is_empty;
      logic        is_full;
   } list_result_type;

   typedef struct packed {
      logic [1:0]      op;
      logic [6:0]      pos;
      logic [31:0]     value;
      logic            typed;    // expectation written out in the row
      list_result_type golden;
   } list_step_type;

   localparam list_result_type NO_RESULT = '0;

   localparam list_step_type DIRECTED_STEPS [N_DIRECTED] = '{
      // empty list
      '{OP_READ,   7'd1,   32'h0,         1'b1, '{STAT_EMPTY,  32'h0, 7'd0, 1'b1, 1'b0}},
      '{OP_DELETE, 7'd1,   32'h0,         1'b1, '{STAT_EMPTY,  32'h0, 7'd0, 1'b1, 1'b0}},
      '{OP_INSERT, 7'd0,   32'h1234_5678, 1'b1, '{STAT_BADPOS, 32'h0, 7'd0, 1'b1, 1'b0}},
      '{OP_INSERT, 7'd2,   32'h1234_5678, 1'b1, '{STAT_BADPOS, 32'h0, 7'd0, 1'b1, 1'b0}},
      '{OP_UNUSED, 7'd1,   32'hFFFF_FFFF, 1'b1, '{STAT_BADPOS, 32'h0, 7'd0, 1'b1, 1'b0}},
      // first entry, then reads around it
      '{OP_INSERT, 7'd1,   32'hFFFF_FFFF, 1'b1, '{STAT_OK,     32'h0, 7'd1, 1'b0, 1'b0}},
      '{OP_READ,   7'd1,   32'h0, 1'b1, '{STAT_OK, 32'hFFFF_FFFF, 7'd1, 1'b0, 1'b0}},
      '{OP_READ,   7'd0,   32'h0,         1'b1, '{STAT_BADPOS, 32'h0, 7'd1, 1'b0, 1'b0}},
      '{OP_READ,   7'd2,   32'h0,         1'b1, '{STAT_BADPOS, 32'h0, 7'd1, 1'b0, 1'b0}},
      // append, insert at head, out-of-range, insert in the middle
      '{OP_INSERT, 7'd2,   32'h0,         1'b1, '{STAT_OK,     32'h0, 7'd2, 1'b0, 1'b0}},
      '{OP_INSERT, 7'd1,   32'hA5A5_A5A5, 1'b1, '{STAT_OK,     32'h0, 7'd3, 1'b0, 1'b0}},
      '{OP_INSERT, 7'd127, 32'hDEAD_BEEF, 1'b1, '{STAT_BADPOS, 32'h0, 7'd3, 1'b0, 1'b0}},
      '{OP_INSERT, 7'd3,   32'h5A5A_5A5A, 1'b0, NO_RESULT},
      '{OP_READ,   7'd3,   32'h0,         1'b0, NO_RESULT},
      '{OP_READ,   7'd4,   32'h0,         1'b0, NO_RESULT},
      '{OP_UNUSED, 7'd2,   32'h0,         1'b1, '{STAT_BADPOS, 32'h0, 7'd4, 1'b0, 1'b0}},
      '{OP_DELETE, 7'd0,   32'h0,         1'b1, '{STAT_BADPOS, 32'h0, 7'd4, 1'b0, 1'b0}},
      '{OP_DELETE, 7'd5,   32'h0,         1'b1, '{STAT_BADPOS, 32'h0, 7'd4, 1'b0, 1'b0}},
      // delete from the middle, then the tail
      '{OP_DELETE, 7'd2,   32'h0,         1'b0, NO_RESULT},
      '{OP_DELETE, 7'd3,   32'h0,         1'b0, NO_RESULT},
      '{OP_READ,   7'd2,   32'h0,         1'b0, NO_RESULT},
      // full list: full wins over a bad position
      '{OP_INSERT, 7'd65,  32'h0,         1'b1, '{STAT_FULL,   32'h0, 7'd64, 1'b0, 1'b1}},
      '{OP_INSERT, 7'd1,   32'h0,         1'b1, '{STAT_FULL,   32'h0, 7'd64, 1'b0, 1'b1}},
      '{OP_READ,   7'd64,  32'h0,         1'b0, NO_RESULT},
      '{OP_DELETE, 7'd65,  32'h0,         1'b1, '{STAT_BADPOS, 32'h0, 7'd64, 1'b0, 1'b1}},
      '{OP_DELETE, 7'd1,   32'h0,         1'b0, NO_RESULT}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_op = OP_READ;
   logic [6:0]  req_position = '0;
   logic [31:0] req_entry_in = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_entry_out;
   logic [6:0]  rsp_length;
   logic        rsp_is_empty;
   logic        rsp_is_full;

   // shadow copy of the list
   logic [31:0]  shadow_entries [CAPACITY];
   int           shadow_len = 0;

   list_result_type pending_results [$];
   list_result_type oldest;
   int unsigned  mismatches = 0;
   int unsigned  cycles = 0;
   int unsigned  idle_pct = 30;
   int unsigned  op_tally [4] = '{0, 0, 0, 0};
   int unsigned  status_tally [4] = '{0, 0, 0, 0};
   int           peak_len = 0;
   int           row, phase, k;
   bit           grow;

   positional_array_list DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_position  (req_position),
      .req_entry_in  (req_entry_in),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_entry_out (rsp_entry_out),
      .rsp_length    (rsp_length),
      .rsp_is_empty  (rsp_is_empty),
      .rsp_is_full   (rsp_is_full)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Applies one operation to the shadow list and returns what the block must answer.
   function automatic list_result_type list_apply(input logic [1:0] op, input logic [6:0] pos,
                                                  input logic [31:0] value);
      list_result_type r;
      int              p;
      int              i;
      r = '0;
      p = int'(pos);
      case (op)
         OP_READ: begin
            if (shadow_len == 0) r.status = STAT_EMPTY;
            else if (p < 1 || p > shadow_len) r.status = STAT_BADPOS;
            else begin
               r.status    = STAT_OK;
               r.entry_out = shadow_entries[p - 1];
            end
         end
         OP_INSERT: begin
            if (shadow_len >= CAPACITY) r.status = STAT_FULL;
            else if (p < 1 || p > shadow_len + 1) r.status = STAT_BADPOS;
            else begin
               for (i = shadow_len; i >= p; i--) shadow_entries[i] = shadow_entries[i - 1];
               shadow_entries[p - 1] = value;
               shadow_len++;
               r.status = STAT_OK;
            end
         end
         OP_DELETE: begin
            if (shadow_len == 0) r.status = STAT_EMPTY;
            else if (p < 1 || p > shadow_len) r.status = STAT_BADPOS;
            else begin
               for (i = p - 1; i + 1 < shadow_len; i++) shadow_entries[i] = shadow_entries[i + 1];
               shadow_len--;
               r.status = STAT_OK;
            end
         end
         default: r.status = STAT_BADPOS;
      endcase
      r.length   = 7'(shadow_len);
      r.is_empty = (shadow_len == 0);
      r.is_full  = (shadow_len == CAPACITY);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] mismatch on %s: got 'h%0h, expected 'h%0h", $time, what, got, want);
      mismatches++;
   endtask

   // Presents one operation and holds it until the transfer; start stays up afterwards
   // so that a back-to-back operation does not toggle it.
   task automatic issue_op(input logic [1:0] op, input logic [6:0] pos, input logic [31:0] value,
                           input logic typed, input list_result_type golden);
      list_result_type predicted;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start        <= 1'b1;
      req_op       <= op;
      req_position <= pos;
      req_entry_in <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = list_apply(op, pos, value);
      pending_results.push_back(typed ? golden : predicted);
      op_tally[op]++;
      if (shadow_len > peak_len) peak_len = shadow_len;
   endtask

   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Mostly well-formed traffic steered up or down; some positions are arbitrary.
   task automatic send_random(input bit up);
      int          roll;
      logic [1:0]  op;
      logic [6:0]  pos;
      logic [31:0] value;
      roll = $urandom_range(99);
      if (roll < 3) op = OP_UNUSED;
      else if (roll < 20) op = OP_READ;
      else if (roll < 80) op = up ? OP_INSERT : OP_DELETE;
      else op = up ? OP_DELETE : OP_INSERT;
      if ($urandom_range(99) < 12 || (op != OP_INSERT && shadow_len == 0))
         pos = 7'($urandom_range(127));
      else if (op == OP_INSERT)
         pos = 7'($urandom_range(shadow_len + 1, 1));
      else
         pos = 7'($urandom_range(shadow_len, 1));
      case ($urandom_range(9))
         0:       value = '0;
         1:       value = '1;
         default: value = $urandom();
      endcase
      issue_op(op, pos, value, 1'b0, NO_RESULT);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         status_tally[rsp_status]++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result, status", 32'(rsp_status), 0);
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_status !== oldest.status)
               report_mismatch("status", 32'(rsp_status), 32'(oldest.status));
            if (rsp_entry_out !== oldest.entry_out)
               report_mismatch("entry_out", rsp_entry_out, oldest.entry_out);
            if (rsp_length !== oldest.length)
               report_mismatch("length", 32'(rsp_length), 32'(oldest.length));
            if (rsp_is_empty !== oldest.is_empty)
               report_mismatch("is_empty", 32'(rsp_is_empty), 32'(oldest.is_empty));
            if (rsp_is_full !== oldest.is_full)
               report_mismatch("is_full", 32'(rsp_is_full), 32'(oldest.is_full));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  pending_results.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (row = 0; row < N_DIRECTED; row++) begin
         if (row == FULL_ROWS_AT) begin
            while (shadow_len < CAPACITY)
               issue_op(OP_INSERT, 7'($urandom_range(shadow_len + 1, 1)), $urandom(),
                        1'b0, NO_RESULT);
         end
         issue_op(DIRECTED_STEPS[row].op, DIRECTED_STEPS[row].pos, DIRECTED_STEPS[row].value,
                  DIRECTED_STEPS[row].typed, DIRECTED_STEPS[row].golden);
      end
      drain_results();

      // sender idles 30 %, then 87 %, then never
      grow = 1'b0;
      for (phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 30 : (phase == 1) ? 87 : 0;
         for (k = 0; k < PHASE_ITEMS; k++) begin
            if (grow && shadow_len == CAPACITY && $urandom_range(7) == 0) grow = 1'b0;
            else if (!grow && shadow_len == 0 && $urandom_range(3) == 0) grow = 1'b1;
            send_random(grow);
            if ($urandom_range(99) == 0) drain_results();
         end
         drain_results();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("results never returned, count", pending_results.size(), 0);

      $display("Covered %0d reads, %0d inserts, %0d deletes, %0d unused ops; peak length %0d",
               op_tally[OP_READ], op_tally[OP_INSERT], op_tally[OP_DELETE],
               op_tally[OP_UNUSED], peak_len);
      $display("Answers seen: %0d ok, %0d full, %0d empty, %0d bad position; %0d mismatches",
               status_tally[STAT_OK], status_tally[STAT_FULL], status_tally[STAT_EMPTY],
               status_tally[STAT_BADPOS], mismatches);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
